FILE: design/ttm_pkg.sv
// shared types and constants for the twin thruster mixer
// no dependencies; compiled first
package ttm_pkg;

  // drive mode, as shown on the result channel
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } ttm_mode_t;

  // configuration register map, one 32-bit word per register
  typedef enum logic [2:0] {
    REG_PULSE_MIN     = 3'd0,
    REG_PULSE_MAX     = 3'd1,
    REG_PULSE_START   = 3'd2,
    REG_LOW_ZONE      = 3'd3,
    REG_HIGH_ZONE     = 3'd4,
    REG_HOLD_TICKS    = 3'd5,
    REG_RAMP_INTERVAL = 3'd6,
    REG_RAMP_STEP     = 3'd7
  } ttm_reg_t;

  // stick gestures seen on one tick
  typedef struct packed {
    logic fwd;
    logic stop;
  } ttm_gesture_t;

  // per-tick status from the mode and ramp logic
  typedef struct packed {
    logic      left_written;
    logic      right_written;
    ttm_mode_t mode;
  } ttm_status_t;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int HOLD_W = 16;
  localparam int RAMP_W = 8;

  localparam int RST_PULSE_MIN     = 1000;
  localparam int RST_PULSE_MAX     = 2000;
  localparam int RST_PULSE_START   = 1100;
  localparam int RST_LOW_ZONE      = 1200;
  localparam int RST_HIGH_ZONE     = 1800;
  localparam int RST_HOLD_TICKS    = 3000;
  localparam int RST_RAMP_INTERVAL = 5;
  localparam int RST_RAMP_STEP     = 2;

  // channel 5 thresholds for the 20 / 50 / 80 percent limits
  localparam int CH5_LOW_SPLIT  = 1250;
  localparam int CH5_HIGH_SPLIT = 1750;

  // throttle mapping
  localparam int THR_IDLE_MAX = 1010;
  localparam int THR_ORIGIN   = 1011;
  localparam int THR_SPAN     = 989;

  // steering mapping: (steer - 1000) * 2 / 5 - 200
  localparam int STEER_ORIGIN = 1000;
  localparam int STEER_SWING  = 200;

  // common divisor of the percent limits and the steering scale
  localparam int FIFTH_DIV = 5;

endpackage

FILE: design/ttm_in_if.sv
// tick channel: valid/ready handshake with the seven pulse-width fields
// no dependencies
interface ttm_in_if #(
  parameter int PULSE_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] chan1;
  logic [PULSE_BITS-1:0] chan2;
  logic [PULSE_BITS-1:0] chan3;
  logic [PULSE_BITS-1:0] chan4;
  logic [PULSE_BITS-1:0] chan5;
  logic [PULSE_BITS-1:0] throttle;
  logic [PULSE_BITS-1:0] steer;

  modport source (
    output valid, chan1, chan2, chan3, chan4, chan5, throttle, steer,
    input  ready
  );

  modport sink (
    input  valid, chan1, chan2, chan3, chan4, chan5, throttle, steer,
    output ready
  );
endinterface

FILE: design/ttm_out_if.sv
// result channel: valid/ready handshake with drive outputs and status
// no dependencies
interface ttm_out_if #(
  parameter int PULSE_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] left_pulse;
  logic [PULSE_BITS-1:0] right_pulse;
  logic                  left_written;
  logic                  right_written;
  logic [1:0]            drive_mode;
  logic [PULSE_BITS-1:0] power_limit;

  modport source (
    output valid, left_pulse, right_pulse, left_written, right_written,
           drive_mode, power_limit,
    input  ready
  );

  modport sink (
    input  valid, left_pulse, right_pulse, left_written, right_written,
           drive_mode, power_limit,
    output ready
  );
endinterface

FILE: design/ttm_ctrl.sv
// gesture mode state machine and upward drive ramp
// depends on ttm_pkg
module ttm_ctrl #(
  parameter int PULSE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  ttm_pkg::ttm_gesture_t       gest,
  input  logic [PULSE_BITS-1:0]       tgt_left,
  input  logic [PULSE_BITS-1:0]       tgt_right,
  input  logic [PULSE_BITS-1:0]       pulse_min,
  input  logic [ttm_pkg::HOLD_W-1:0]  hold_ticks,
  input  logic [ttm_pkg::RAMP_W-1:0]  ramp_interval,
  input  logic [ttm_pkg::RAMP_W-1:0]  ramp_step,
  output logic [PULSE_BITS-1:0]       left_pulse,
  output logic [PULSE_BITS-1:0]       right_pulse,
  output ttm_pkg::ttm_status_t        status
);
  import ttm_pkg::*;

  localparam int PW = PULSE_BITS;

  ttm_mode_t         mode, mode_next;
  logic              armed, armed_next;
  logic [HOLD_W-1:0] hold_count, hold_next, hold_inc;
  logic [RAMP_W-1:0] ramp_count, ramp_next, ramp_inc;
  logic [PW-1:0]     left_drive, left_next;
  logic [PW-1:0]     right_drive, right_next;
  logic              match;
  logic              fire;
  logic              left_wr, right_wr;
  logic [PW-1:0]     tl, tr;

  // raise by at most one step, drop at once
  function automatic logic [PW-1:0] ramp_toward(input logic [PW-1:0] drive,
                                                input logic [PW-1:0] target,
                                                input logic [RAMP_W-1:0] stp);
    logic [PW-1:0] delta;
    logic [PW-1:0] stpx;
    delta = target - drive;
    stpx  = PW'(stp);
    if (target < drive) begin
      return target;
    end
    return drive + ((delta < stpx) ? delta : stpx);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_STOP;
      armed       <= 1'b0;
      hold_count  <= '0;
      ramp_count  <= '0;
      left_drive  <= PW'(RST_PULSE_MIN);
      right_drive <= PW'(RST_PULSE_MIN);
    end else if (step) begin
      mode        <= mode_next;
      armed       <= armed_next;
      hold_count  <= hold_next;
      ramp_count  <= ramp_next;
      left_drive  <= left_next;
      right_drive <= right_next;
    end
  end

  always_comb begin
    hold_inc = (armed && hold_count != '1) ? HOLD_W'(hold_count + 1'b1) : hold_count;
    mode_next  = mode;
    armed_next = armed;
    hold_next  = hold_inc;

    unique case (mode)
      MODE_STOP: match = gest.fwd;
      MODE_FWD:  match = gest.stop;
      default:   match = 1'b0;
    endcase

    if (match) begin
      if (!armed) begin
        armed_next = 1'b1;
        hold_next  = '0;
      end else if (hold_inc >= hold_ticks) begin
        mode_next  = (mode == MODE_STOP) ? MODE_FWD : MODE_STOP;
        armed_next = 1'b0;
        hold_next  = '0;
      end
    end else if (!gest.fwd && !gest.stop) begin
      armed_next = 1'b0;
      hold_next  = '0;
    end

    // targets follow the mode after this tick's gesture
    tl = (mode_next == MODE_FWD) ? tgt_left  : pulse_min;
    tr = (mode_next == MODE_FWD) ? tgt_right : pulse_min;

    ramp_inc  = (ramp_count != '1) ? RAMP_W'(ramp_count + 1'b1) : ramp_count;
    fire      = (ramp_inc >= ramp_interval);
    ramp_next = fire ? '0 : ramp_inc;

    left_wr    = fire && (left_drive != tl);
    right_wr   = fire && (right_drive != tr);
    left_next  = left_wr  ? ramp_toward(left_drive, tl, ramp_step)  : left_drive;
    right_next = right_wr ? ramp_toward(right_drive, tr, ramp_step) : right_drive;
  end

  assign left_pulse           = left_next;
  assign right_pulse          = right_next;
  assign status.left_written  = left_wr;
  assign status.right_written = right_wr;
  assign status.mode          = mode_next;

endmodule

FILE: design/twin_thruster_mixer_with_ramp_top.sv
// twin thruster mixer top level: config registers, target pipeline, result register
// depends on ttm_pkg, ttm_in_if, ttm_out_if, ttm_ctrl
//
// One tick transaction (five RC channels, throttle, steer) gives one result
// transaction (two drive pulses, written flags, mode, power limit). The block
// takes one transaction per clock while the result side accepts, and the result
// passes through an input register, four arithmetic stages and the result
// register. The arithmetic stages depend only on the tick and the config
// registers; all per-tick state (gesture mode, hold counter, ramp counter,
// drive values) sits in ttm_ctrl and is updated in the single cycle in which
// a tick moves into the result register, so consecutive ticks never wait on
// each other. Each stage holds its data while the next one cannot load, so a
// stalled result side fills the pipeline before tick.ready drops. Config
// registers sit on an APB-style port, one 32-bit word each, and must only be
// written while no tick is in flight. No memory, no clearing pass after reset.
module twin_thruster_mixer_with_ramp_top #(
  parameter int PULSE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  ttm_in_if.sink                      tick,
  ttm_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttm_pkg::APB_AW-1:0]  paddr,
  input  logic [ttm_pkg::APB_DW-1:0]  pwdata,
  output logic [ttm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ttm_pkg::*;

  localparam int PW = PULSE_BITS;
  localparam int DW = PW + 1;          // signed difference of two pulses
  localparam int XW = PW + 2;          // dividend of the divide-by-five
  localparam int S5SH = XW + 3;        // reciprocal shift for five
  localparam int M5W = XW + 1;
  localparam int PR5W = XW + M5W;
  localparam logic [63:0] M5_FULL =
    ((64'd1 << S5SH) + 64'(FIFTH_DIV - 1)) / 64'(FIFTH_DIV);
  localparam logic [M5W-1:0] M5 = M5_FULL[M5W-1:0];
  localparam int W = 2 * PW;           // throttle product
  localparam int S9 = W + 10;          // reciprocal shift for the throttle span
  localparam int M9W = W + 1;
  localparam int PR9W = W + M9W;
  localparam logic [63:0] M9_FULL =
    ((64'd1 << S9) + 64'(THR_SPAN - 1)) / 64'(THR_SPAN);
  localparam logic [M9W-1:0] M989 = M9_FULL[M9W-1:0];
  localparam int QW = W - 9;           // quotient of the throttle product
  localparam int BW = QW + 2;          // signed base
  localparam int SW = BW + 1;          // signed base plus or minus steering

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [PW-1:0]     pulse_min, pulse_max, pulse_start, low_zone, high_zone;
  logic [HOLD_W-1:0] hold_ticks;
  logic [RAMP_W-1:0] ramp_interval, ramp_step;
  logic              wr_en;
  ttm_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = ttm_reg_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min     <= PW'(RST_PULSE_MIN);
      pulse_max     <= PW'(RST_PULSE_MAX);
      pulse_start   <= PW'(RST_PULSE_START);
      low_zone      <= PW'(RST_LOW_ZONE);
      high_zone     <= PW'(RST_HIGH_ZONE);
      hold_ticks    <= HOLD_W'(RST_HOLD_TICKS);
      ramp_interval <= RAMP_W'(RST_RAMP_INTERVAL);
      ramp_step     <= RAMP_W'(RST_RAMP_STEP);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PULSE_MIN:     pulse_min     <= pwdata[PW-1:0];
        REG_PULSE_MAX:     pulse_max     <= pwdata[PW-1:0];
        REG_PULSE_START:   pulse_start   <= pwdata[PW-1:0];
        REG_LOW_ZONE:      low_zone      <= pwdata[PW-1:0];
        REG_HIGH_ZONE:     high_zone     <= pwdata[PW-1:0];
        REG_HOLD_TICKS:    hold_ticks    <= pwdata[HOLD_W-1:0];
        REG_RAMP_INTERVAL: ramp_interval <= pwdata[RAMP_W-1:0];
        REG_RAMP_STEP:     ramp_step     <= pwdata[RAMP_W-1:0];
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_PULSE_MIN:     prdata = APB_DW'(pulse_min);
      REG_PULSE_MAX:     prdata = APB_DW'(pulse_max);
      REG_PULSE_START:   prdata = APB_DW'(pulse_start);
      REG_LOW_ZONE:      prdata = APB_DW'(low_zone);
      REG_HIGH_ZONE:     prdata = APB_DW'(high_zone);
      REG_HOLD_TICKS:    prdata = APB_DW'(hold_ticks);
      REG_RAMP_INTERVAL: prdata = APB_DW'(ramp_interval);
      REG_RAMP_STEP:     prdata = APB_DW'(ramp_step);
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, out_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, out_free;
  logic step;

  assign out_free   = !out_valid || result.ready;
  assign rdy5       = !s5_valid || out_free;
  assign rdy4       = !s4_valid || rdy5;
  assign rdy3       = !s3_valid || rdy4;
  assign rdy2       = !s2_valid || rdy3;
  assign rdy1       = !s1_valid || rdy2;
  assign tick.ready = rdy1;
  // a tick commits its state update when it enters the result register
  assign step       = s5_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)     s1_valid  <= tick.valid;
      if (rdy2)     s2_valid  <= s1_valid;
      if (rdy3)     s3_valid  <= s2_valid;
      if (rdy4)     s4_valid  <= s3_valid;
      if (rdy5)     s5_valid  <= s4_valid;
      if (out_free) out_valid <= s5_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] s1_c1, s1_c2, s1_c3, s1_c4, s1_c5, s1_thr, s1_str;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_c1  <= tick.chan1;
      s1_c2  <= tick.chan2;
      s1_c3  <= tick.chan3;
      s1_c4  <= tick.chan4;
      s1_c5  <= tick.chan5;
      s1_thr <= tick.throttle;
      s1_str <= tick.steer;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 -> 2: power limit, steering differential, throttle product, gestures
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]   lim_d;
  logic                   lim_neg;
  logic [PW-1:0]          lim_mag;
  logic                   pct20, pct50;
  logic [XW-1:0]          lim_x;
  logic [PR5W-1:0]        lim_prod;
  logic [PW-1:0]          lim_q;
  logic signed [DW-1:0]   lim_scaled;
  logic [PW-1:0]          limit_c;

  logic signed [DW-1:0]   str_d;
  logic                   str_neg;
  logic [PW-1:0]          str_mag;
  logic [XW-1:0]          str_x;
  logic [PR5W-1:0]        str_prod;
  logic [PW-1:0]          str_q;
  logic signed [PW+1:0]   diff_c;

  logic                   thr_on_c;
  logic [PW-1:0]          thr_off;
  logic signed [DW-1:0]   span_d;
  logic                   span_neg;
  logic [PW-1:0]          span_mag;
  logic [W-1:0]           bprod_c;
  ttm_gesture_t           gest_c;

  always_comb begin
    // limit = pulse_min + (pulse_max - pulse_min) * pct / 100, truncated
    lim_d    = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
    lim_neg  = lim_d[DW-1];
    lim_mag  = lim_neg ? PW'(-lim_d) : lim_d[PW-1:0];
    pct20    = s1_c5 < PW'(CH5_LOW_SPLIT);
    pct50    = !pct20 && (s1_c5 < PW'(CH5_HIGH_SPLIT));
    // 20 percent is a fifth, 80 percent is four fifths, 50 percent a shift
    lim_x    = pct20 ? XW'(lim_mag) : {lim_mag, 2'b00};
    lim_prod = PR5W'(lim_x) * PR5W'(M5);
    lim_q    = pct50 ? {1'b0, lim_mag[PW-1:1]} : lim_prod[S5SH +: PW];
    lim_scaled = lim_neg ? -$signed({1'b0, lim_q}) : $signed({1'b0, lim_q});
    limit_c  = PW'($signed({1'b0, pulse_min}) + lim_scaled);

    // steering: (steer - 1000) * 2 / 5 - 200, truncated toward zero
    str_d    = $signed({1'b0, s1_str}) - $signed(DW'(STEER_ORIGIN));
    str_neg  = str_d[DW-1];
    str_mag  = str_neg ? PW'(-str_d) : str_d[PW-1:0];
    str_x    = XW'({str_mag, 1'b0});
    str_prod = PR5W'(str_x) * PR5W'(M5);
    str_q    = str_prod[S5SH +: PW];
    diff_c   = (str_neg ? -$signed({2'b00, str_q}) : $signed({2'b00, str_q}))
               - $signed((PW+2)'(STEER_SWING));

    // throttle above idle: (throttle - 1011) * (pulse_max - pulse_start)
    thr_on_c = s1_thr > PW'(THR_IDLE_MAX);
    thr_off  = s1_thr - PW'(THR_ORIGIN);
    span_d   = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_start});
    span_neg = span_d[DW-1];
    span_mag = span_neg ? PW'(-span_d) : span_d[PW-1:0];
    bprod_c  = W'(thr_off) * W'(span_mag);

    gest_c.fwd  = (s1_c1 < low_zone) && (s1_c2 > high_zone) &&
                  (s1_c3 < low_zone) && (s1_c4 > high_zone);
    gest_c.stop = (s1_c1 < low_zone) && (s1_c2 < low_zone) &&
                  (s1_c3 < low_zone) && (s1_c4 > high_zone);
  end

  logic [PW-1:0]        s2_limit;
  logic signed [PW+1:0] s2_diff;
  logic [W-1:0]         s2_bprod;
  logic                 s2_bneg;
  logic                 s2_thr_on;
  ttm_gesture_t         s2_gest;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_limit  <= limit_c;
      s2_diff   <= diff_c;
      s2_bprod  <= bprod_c;
      s2_bneg   <= span_neg;
      s2_thr_on <= thr_on_c;
      s2_gest   <= gest_c;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 -> 3: divide the throttle product by 989 via reciprocal
  // ---------------------------------------------------------------------------
  logic [PR9W-1:0] b9_prod;

  assign b9_prod = PR9W'(s2_bprod) * PR9W'(M989);

  logic [QW-1:0]        s3_qb;
  logic                 s3_bneg;
  logic [PW-1:0]        s3_limit;
  logic signed [PW+1:0] s3_diff;
  logic                 s3_thr_on;
  ttm_gesture_t         s3_gest;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_qb     <= b9_prod[S9 +: QW];
      s3_bneg   <= s2_bneg;
      s3_limit  <= s2_limit;
      s3_diff   <= s2_diff;
      s3_thr_on <= s2_thr_on;
      s3_gest   <= s2_gest;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3 -> 4: base pulse and the two mixed sums
  // ---------------------------------------------------------------------------
  logic signed [BW-1:0] qb_s;
  logic signed [BW-1:0] base;
  logic signed [SW-1:0] sum_l_c, sum_r_c;

  always_comb begin
    qb_s    = $signed({2'b00, s3_qb});
    base    = $signed(BW'(pulse_start)) + (s3_bneg ? -qb_s : qb_s);
    sum_l_c = SW'(base) + SW'(s3_diff);
    sum_r_c = SW'(base) - SW'(s3_diff);
  end

  logic signed [SW-1:0] s4_sum_l, s4_sum_r;
  logic [PW-1:0]        s4_limit;
  logic                 s4_thr_on;
  ttm_gesture_t         s4_gest;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_sum_l  <= sum_l_c;
      s4_sum_r  <= sum_r_c;
      s4_limit  <= s3_limit;
      s4_thr_on <= s3_thr_on;
      s4_gest   <= s3_gest;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4 -> 5: idle target min(pulse_min, limit), else clamp to [pulse_min, limit], minimum tested first
  // ---------------------------------------------------------------------------
  function automatic logic [PW-1:0] clamp_pulse(input logic signed [SW-1:0] x,
                                                input logic [PW-1:0] lo,
                                                input logic [PW-1:0] hi);
    if (x < $signed(SW'(lo))) begin
      return lo;
    end
    if (x > $signed(SW'(hi))) begin
      return hi;
    end
    return x[PW-1:0];
  endfunction

  logic [PW-1:0] idle_tgt, tgt_l_c, tgt_r_c;

  always_comb begin
    idle_tgt = (pulse_min > s4_limit) ? s4_limit : pulse_min;
    tgt_l_c  = s4_thr_on ? clamp_pulse(s4_sum_l, pulse_min, s4_limit) : idle_tgt;
    tgt_r_c  = s4_thr_on ? clamp_pulse(s4_sum_r, pulse_min, s4_limit) : idle_tgt;
  end

  logic [PW-1:0] s5_tgt_l, s5_tgt_r, s5_limit;
  ttm_gesture_t  s5_gest;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_tgt_l <= tgt_l_c;
      s5_tgt_r <= tgt_r_c;
      s5_limit <= s4_limit;
      s5_gest  <= s4_gest;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5 -> result: mode state machine and ramp, then the result register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] left_c, right_c;
  ttm_status_t   status_c;

  ttm_ctrl #(
    .PULSE_BITS (PULSE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .gest          (s5_gest),
    .tgt_left      (s5_tgt_l),
    .tgt_right     (s5_tgt_r),
    .pulse_min     (pulse_min),
    .hold_ticks    (hold_ticks),
    .ramp_interval (ramp_interval),
    .ramp_step     (ramp_step),
    .left_pulse    (left_c),
    .right_pulse   (right_c),
    .status        (status_c)
  );

  logic [PW-1:0] out_left, out_right, out_limit;
  ttm_status_t   out_status;

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_left   <= left_c;
      out_right  <= right_c;
      out_limit  <= s5_limit;
      out_status <= status_c;
    end
  end

  assign result.valid         = out_valid;
  assign result.left_pulse    = out_left;
  assign result.right_pulse   = out_right;
  assign result.left_written  = out_status.left_written;
  assign result.right_written = out_status.right_written;
  assign result.drive_mode    = out_status.mode;
  assign result.power_limit   = out_limit;

endmodule

FILE: design/ttm_check.sv
// port-level checks for the twin thruster mixer, bound to the top level
// depends on ttm_pkg and twin_thruster_mixer_with_ramp_top
module ttm_check #(
  parameter int PULSE_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  tick_valid,
  input logic                  tick_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [PULSE_BITS-1:0] res_left,
  input logic [PULSE_BITS-1:0] res_right,
  input logic                  res_lw,
  input logic                  res_rw,
  input logic [1:0]            res_mode,
  input logic [PULSE_BITS-1:0] res_limit
);
  import ttm_pkg::*;

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_left) &&
      $stable(res_right) && $stable(res_lw) && $stable(res_rw) &&
      $stable(res_mode) && $stable(res_limit))
    else $error("result changed while stalled");

  // reverse is never entered
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_mode == MODE_STOP || res_mode == MODE_FWD))
    else $error("illegal drive mode");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // with the result register empty the whole pipeline can move
  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick_ready)
    else $error("tick stalled with empty result register");

  // tick_valid is only watched for completeness of the port view
  a_tick_seen: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready && !res_valid |=> 1'b1)
    else $error("unreachable");

endmodule

bind twin_thruster_mixer_with_ramp_top ttm_check #(
  .PULSE_BITS (PULSE_BITS)
) u_ttm_check (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_left   (result.left_pulse),
  .res_right  (result.right_pulse),
  .res_lw     (result.left_written),
  .res_rw     (result.right_written),
  .res_mode   (result.drive_mode),
  .res_limit  (result.power_limit)
);
